/* rtl/core/tjr_pkg.sv */
// Shared types and constants for the timer and joypad IO register block.
package tjr_pkg;

    // Command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // Register offsets within the IO page
    localparam logic [7:0] ADDR_JOYP  = 8'h00;
    localparam logic [7:0] ADDR_SB    = 8'h01;
    localparam logic [7:0] ADDR_SC    = 8'h02;
    localparam logic [7:0] ADDR_DIV   = 8'h04;
    localparam logic [7:0] ADDR_TIMA  = 8'h05;
    localparam logic [7:0] ADDR_TMA   = 8'h06;
    localparam logic [7:0] ADDR_TAC   = 8'h07;
    localparam logic [7:0] ADDR_KEY1  = 8'h4D;
    localparam logic [7:0] ADDR_SPARE = 8'h7F;

    // Joypad register masks and select codes
    localparam logic [7:0] JOYP_KEEP   = 8'hCF;
    localparam logic [7:0] JOYP_SEL    = 8'h30;
    localparam logic [7:0] JOYP_LOW    = 8'h0F;
    localparam logic [1:0] JOYP_ROW_LO = 2'b01;
    localparam logic [1:0] JOYP_ROW_HI = 2'b10;
    localparam logic [7:0] JOYP_RESET  = 8'hFF;

    // Timer control fields
    localparam int unsigned TAC_ENABLE_BIT = 2;
    localparam logic [1:0] TAC_MODE_DIV4  = 2'd0;
    localparam logic [1:0] TAC_MODE_MUL16 = 2'd1;
    localparam logic [1:0] TAC_MODE_MUL4  = 2'd2;

    localparam logic [7:0] BYTE_ONES = 8'hFF;

    // Address decode result
    typedef struct packed {
        logic joyp;
        logic serial;
        logic div;
        logic tima;
        logic tma;
        logic tac;
        logic audio;
        logic video;
        logic key1;
        logic spare;
    } t_addr_dec;

endpackage

/* rtl/core/tjr_addr_dec.sv */
// IO page address decoder for the timer and joypad register block.
module tjr_addr_dec (
    input  logic [7:0]         i_reg_address,
    output tjr_pkg::t_addr_dec o_dec
);
    import tjr_pkg::*;

    // One flag per register group
    always_comb begin
        o_dec        = '0;
        o_dec.joyp   = (i_reg_address == ADDR_JOYP);
        o_dec.serial = (i_reg_address == ADDR_SB) || (i_reg_address == ADDR_SC);
        o_dec.div    = (i_reg_address == ADDR_DIV);
        o_dec.tima   = (i_reg_address == ADDR_TIMA);
        o_dec.tma    = (i_reg_address == ADDR_TMA);
        o_dec.tac    = (i_reg_address == ADDR_TAC);
        o_dec.audio  = (i_reg_address >= 8'h10 && i_reg_address <= 8'h14) ||
                       (i_reg_address >= 8'h16 && i_reg_address <= 8'h1E) ||
                       (i_reg_address >= 8'h20 && i_reg_address <= 8'h26) ||
                       (i_reg_address >= 8'h30 && i_reg_address <= 8'h3F);
        o_dec.video  = (i_reg_address >= 8'h40 && i_reg_address <= 8'h45) ||
                       (i_reg_address >= 8'h47 && i_reg_address <= 8'h4B);
        o_dec.key1   = (i_reg_address == ADDR_KEY1);
        o_dec.spare  = (i_reg_address == ADDR_SPARE);
    end

endmodule

/* rtl/core/tjr_state.sv */
// Timer, divider and joypad state registers with the per-item update logic.
module tjr_state (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [1:0]         i_command,
    input  tjr_pkg::t_addr_dec i_dec,
    input  logic [7:0]         i_write_value,
    input  logic [7:0]         i_tick_cycles,
    input  logic [7:0]         i_button_state,
    output logic [7:0]         o_read_value,
    output logic               o_video_access,
    output logic               o_bad_address,
    output logic               o_timer_irq_pending
);
    import tjr_pkg::*;

    logic [7:0]  r_joyp, n_joyp;
    logic [15:0] r_div, n_div;
    logic [15:0] r_tima, n_tima;
    logic [7:0]  r_tma, n_tma;
    logic [7:0]  r_tac, n_tac;
    logic        r_irq, n_irq;

    logic [11:0] w_add;
    logic [16:0] w_sum;
    logic [7:0]  w_joyp_wr;

    // Mode-scaled timer increment (counter carries 4 fraction bits)
    always_comb begin
        case (r_tac[1:0])
            TAC_MODE_DIV4:  w_add = {6'd0, i_tick_cycles[7:2]};
            TAC_MODE_MUL16: w_add = {i_tick_cycles, 4'd0};
            TAC_MODE_MUL4:  w_add = {2'd0, i_tick_cycles, 2'd0};
            default:        w_add = {4'd0, i_tick_cycles};
        endcase
        w_sum = {1'b0, r_tima} + {5'd0, w_add};
    end

    // Joypad select write: keep top bits, pick a button row
    always_comb begin
        w_joyp_wr = (r_joyp & JOYP_KEEP) | (i_write_value & JOYP_SEL) | JOYP_LOW;
        if (w_joyp_wr[5:4] == JOYP_ROW_LO) begin
            w_joyp_wr[3:0] = w_joyp_wr[3:0] & i_button_state[3:0];
        end else if (w_joyp_wr[5:4] == JOYP_ROW_HI) begin
            w_joyp_wr[3:0] = w_joyp_wr[3:0] & i_button_state[7:4];
        end
    end

    // Next state and result for the current item
    always_comb begin
        n_joyp         = r_joyp;
        n_div          = r_div;
        n_tima         = r_tima;
        n_tma          = r_tma;
        n_tac          = r_tac;
        n_irq          = r_irq;
        o_read_value   = 8'd0;
        o_video_access = 1'b0;
        o_bad_address  = 1'b0;
        unique case (i_command)
            CMD_TICK: begin
                n_div = r_div + {8'd0, i_tick_cycles};
                if (!r_tac[TAC_ENABLE_BIT]) begin
                    n_tima = '0;
                end else if (w_sum[16]) begin
                    n_irq  = 1'b1;
                    n_tima = {4'd0, r_tma, 4'd0};
                end else begin
                    n_tima = w_sum[15:0];
                end
            end
            CMD_READ: begin
                if (i_dec.joyp) begin
                    o_read_value = r_joyp;
                end else if (i_dec.serial || i_dec.audio) begin
                    o_read_value = 8'd0;
                end else if (i_dec.div) begin
                    o_read_value = r_div[11:4];
                end else if (i_dec.tima) begin
                    o_read_value = r_tima[11:4];
                end else if (i_dec.tma) begin
                    o_read_value = r_tma;
                end else if (i_dec.tac) begin
                    o_read_value = r_tac;
                end else if (i_dec.video) begin
                    o_video_access = 1'b1;
                end else if (i_dec.key1) begin
                    o_read_value = BYTE_ONES;
                end else begin
                    o_bad_address = 1'b1;
                    o_read_value  = BYTE_ONES;
                end
            end
            CMD_WRITE: begin
                if (i_dec.joyp) begin
                    n_joyp = w_joyp_wr;
                end else if (i_dec.div) begin
                    n_div = '0;
                end else if (i_dec.tima) begin
                    n_tima = {4'd0, i_write_value, 4'd0};
                end else if (i_dec.tma) begin
                    n_tma = i_write_value;
                end else if (i_dec.tac) begin
                    n_tac = i_write_value;
                end else if (i_dec.video) begin
                    o_video_access = 1'b1;
                end else if (!(i_dec.serial || i_dec.spare || i_dec.audio)) begin
                    o_bad_address = 1'b1;
                end
            end
            default: begin
                // undefined command: no effect
            end
        endcase
        o_timer_irq_pending = n_irq;
    end

    // State registers, updated once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_joyp <= JOYP_RESET;
            r_div  <= '0;
            r_tima <= '0;
            r_tma  <= '0;
            r_tac  <= '0;
            r_irq  <= 1'b0;
        end else if (i_step) begin
            r_joyp <= n_joyp;
            r_div  <= n_div;
            r_tima <= n_tima;
            r_tma  <= n_tma;
            r_tac  <= n_tac;
            r_irq  <= n_irq;
        end
    end

    // Interrupt flag is sticky until reset
    a_irq_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_irq |=> r_irq)
        else $error("timer irq flag cleared without reset");

    // A tick with the timer disabled leaves the counter at zero
    a_tima_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_command == CMD_TICK && !r_tac[TAC_ENABLE_BIT]) |=> (r_tima == '0))
        else $error("timer counter not cleared while disabled");

    // Joypad bits 7..6 never change after reset
    a_joyp_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_joyp[7:6] == JOYP_RESET[7:6]))
        else $error("joypad upper bits changed");

endmodule

/* rtl/core/timer_joypad_io_registers.sv */
// Top level of the timer, divider and joypad IO register block.
//
// Input channel: i_valid / o_stall carry one item (command, register address,
// write data, tick cycle count, button state). An item is taken at a clock
// edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry one result per item (read data,
// video-access flag, bad-address flag, timer interrupt flag after the item).
// A result is taken at an edge with o_valid high and i_stall low.
// Each item passes through an input register, decode and state update
// logic, and a result register; the result register takes the item's
// result, and raises o_valid, once it is empty or being read. One item
// per cycle is sustained while the receiver does not stall.
// The state update and result come from short adds and an address
// decode between those two registers.
// When the receiver stalls, the result register holds; one more item can
// still wait in the input register, after which o_stall rises.
// Synchronous reset (i_rst_n low) empties both registers and sets the
// joypad register to 0xFF and all timer state and the interrupt flag to 0.
module timer_joypad_io_registers (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_command,
    input  logic [7:0] i_reg_address,
    input  logic [7:0] i_write_value,
    input  logic [7:0] i_tick_cycles,
    input  logic [7:0] i_button_state,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_read_value,
    output logic       o_video_access,
    output logic       o_bad_address,
    output logic       o_timer_irq_pending
);
    import tjr_pkg::*;

    logic       r_in_valid;
    logic [1:0] r_in_command;
    logic [7:0] r_in_address;
    logic [7:0] r_in_wdata;
    logic [7:0] r_in_cycles;
    logic [7:0] r_in_buttons;

    logic       r_out_valid;
    logic [7:0] r_out_rdata;
    logic       r_out_video;
    logic       r_out_bad;
    logic       r_out_irq;

    logic       w_out_ready;
    logic       w_adv;
    logic       w_in_take;
    t_addr_dec  w_dec;
    logic [7:0] w_rdata;
    logic       w_video;
    logic       w_bad;
    logic       w_irq;

    // Handshake
    assign w_out_ready = !r_out_valid || !i_stall;
    assign w_adv       = r_in_valid && w_out_ready;
    assign o_stall     = r_in_valid && !w_out_ready;
    assign w_in_take   = i_valid && !o_stall;

    tjr_addr_dec u_dec (
        .i_reg_address (r_in_address),
        .o_dec         (w_dec)
    );

    tjr_state u_state (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_step              (w_adv),
        .i_command           (r_in_command),
        .i_dec               (w_dec),
        .i_write_value       (r_in_wdata),
        .i_tick_cycles       (r_in_cycles),
        .i_button_state      (r_in_buttons),
        .o_read_value        (w_rdata),
        .o_video_access      (w_video),
        .o_bad_address       (w_bad),
        .o_timer_irq_pending (w_irq)
    );

    // Valid bits of the input and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (w_out_ready) begin
                r_out_valid <= w_adv;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_command <= i_command;
            r_in_address <= i_reg_address;
            r_in_wdata   <= i_write_value;
            r_in_cycles  <= i_tick_cycles;
            r_in_buttons <= i_button_state;
        end
        if (w_adv) begin
            r_out_rdata <= w_rdata;
            r_out_video <= w_video;
            r_out_bad   <= w_bad;
            r_out_irq   <= w_irq;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_read_value        = r_out_rdata;
    assign o_video_access      = r_out_video;
    assign o_bad_address       = r_out_bad;
    assign o_timer_irq_pending = r_out_irq;

    // An item leaving the input register shows up as a result next cycle
    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("processed item did not reach result register");

    // Video and bad-address flags are exclusive
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_video && r_out_bad))
        else $error("video and bad-address flags both set");

    // Stall only when both registers are occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid))
        else $error("stall raised with a free register");

endmodule

/* tb/timer_joypad_io_registers_test.sv */
// Self-checking testbench for the timer, divider and joypad IO register block.
module timer_joypad_io_registers_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tjr_pkg::*;

    // Command code that the block treats as a no-op
    localparam logic [1:0] CMD_NONE = 2'd3;

    // IO page ranges owned by the video and audio blocks
    localparam logic [7:0] VIDEO_A_LO = 8'h40;
    localparam logic [7:0] VIDEO_A_HI = 8'h45;
    localparam logic [7:0] VIDEO_B_LO = 8'h47;
    localparam logic [7:0] VIDEO_B_HI = 8'h4B;
    localparam logic [7:0] VIDEO_GAP  = 8'h46;
    localparam logic [7:0] AUDIO_A_LO = 8'h10;
    localparam logic [7:0] AUDIO_A_HI = 8'h14;
    localparam logic [7:0] AUDIO_B_LO = 8'h16;
    localparam logic [7:0] AUDIO_B_HI = 8'h1E;
    localparam logic [7:0] AUDIO_C_LO = 8'h20;
    localparam logic [7:0] AUDIO_C_HI = 8'h26;
    localparam logic [7:0] AUDIO_D_LO = 8'h30;
    localparam logic [7:0] AUDIO_D_HI = 8'h3F;
    localparam logic [7:0] AUDIO_GAP  = 8'h15;
    localparam logic [7:0] ADDR_HOLE  = 8'h03;
    localparam logic [7:0] ADDR_TOP   = 8'hFF;

    localparam int ITEM_TOTAL     = 1600;
    localparam int CALM_TAIL      = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] address;
        logic [7:0] wdata;
        logic [7:0] cycles;
        logic [7:0] buttons;
    } bus_item_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       video;
        logic       bad;
        logic       irq;
    } bus_reply_t;

    // Tracks the register state and the replies still owed by the block
    class io_page_board;
        logic [7:0]  joypad;
        logic [15:0] divider;
        logic [15:0] counter;
        logic [7:0]  reload;
        logic [7:0]  control;
        logic        irq_flag;
        bus_reply_t  pending_replies[$];
        int          mismatches;

        function new();
            joypad     = JOYP_RESET;
            divider    = '0;
            counter    = '0;
            reload     = '0;
            control    = '0;
            irq_flag   = 1'b0;
            mismatches = 0;
        endfunction

        function bit is_audio(logic [7:0] a);
            return (a >= AUDIO_A_LO && a <= AUDIO_A_HI) || (a >= AUDIO_B_LO && a <= AUDIO_B_HI) ||
                   (a >= AUDIO_C_LO && a <= AUDIO_C_HI) || (a >= AUDIO_D_LO && a <= AUDIO_D_HI);
        endfunction

        function bit is_video(logic [7:0] a);
            return (a >= VIDEO_A_LO && a <= VIDEO_A_HI) || (a >= VIDEO_B_LO && a <= VIDEO_B_HI);
        endfunction

        // Divider always runs; the counter adds a mode-scaled step with 4 fraction bits
        function void advance_timer(logic [7:0] cycles);
            logic [15:0] step;
            logic [16:0] total;
            divider = divider + {8'h00, cycles};
            if (!control[TAC_ENABLE_BIT]) begin
                counter = '0;
                return;
            end
            case (control[1:0])
                TAC_MODE_DIV4:  step = {10'h000, cycles[7:2]};
                TAC_MODE_MUL16: step = {4'h0, cycles, 4'h0};
                TAC_MODE_MUL4:  step = {6'h00, cycles, 2'b00};
                default:        step = {8'h00, cycles};
            endcase
            total = {1'b0, counter} + {1'b0, step};
            if (total[16]) begin
                irq_flag = 1'b1;
                counter  = {4'h0, reload, 4'h0};
            end else begin
                counter = total[15:0];
            end
        endfunction

        // Update the state for one accepted item and queue the reply it owes
        function void apply_item(bus_item_t it);
            bus_reply_t r;
            logic [7:0] a;
            logic [7:0] j;
            r = '0;
            a = it.address;
            case (it.command)
                CMD_TICK: advance_timer(it.cycles);
                CMD_READ: begin
                    if (a == ADDR_JOYP) r.rdata = joypad;
                    else if (a == ADDR_SB || a == ADDR_SC || is_audio(a)) r.rdata = '0;
                    else if (a == ADDR_DIV) r.rdata = divider[11:4];
                    else if (a == ADDR_TIMA) r.rdata = counter[11:4];
                    else if (a == ADDR_TMA) r.rdata = reload;
                    else if (a == ADDR_TAC) r.rdata = control;
                    else if (is_video(a)) r.video = 1'b1;
                    else if (a == ADDR_KEY1) r.rdata = BYTE_ONES;
                    else begin
                        r.bad   = 1'b1;
                        r.rdata = BYTE_ONES;
                    end
                end
                CMD_WRITE: begin
                    if (a == ADDR_JOYP) begin
                        // select bits from the write, upper bits kept, chosen row masks low nibble
                        j = (joypad & JOYP_KEEP) | (it.wdata & JOYP_SEL) | JOYP_LOW;
                        if (j[5:4] == JOYP_ROW_LO) j[3:0] = j[3:0] & it.buttons[3:0];
                        else if (j[5:4] == JOYP_ROW_HI) j[3:0] = j[3:0] & it.buttons[7:4];
                        joypad = j;
                    end
                    else if (a == ADDR_DIV) divider = '0;
                    else if (a == ADDR_TIMA) counter = {4'h0, it.wdata, 4'h0};
                    else if (a == ADDR_TMA) reload = it.wdata;
                    else if (a == ADDR_TAC) control = it.wdata;
                    else if (is_video(a)) r.video = 1'b1;
                    else if (!(a == ADDR_SB || a == ADDR_SC || a == ADDR_SPARE || is_audio(a)))
                        r.bad = 1'b1;
                end
                default: ;
            endcase
            r.irq = irq_flag;
            pending_replies.push_back(r);
        endfunction

        function void flag_mismatch(string field, logic [7:0] want, logic [7:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %02h, got %02h", $time, field, want, got);
        endfunction

        function void check_reply(bus_reply_t got);
            bus_reply_t want;
            if (pending_replies.size() == 0) begin
                flag_mismatch("unexpected reply", '0, got.rdata);
                return;
            end
            want = pending_replies.pop_front();
            if (got.rdata !== want.rdata) flag_mismatch("read_value", want.rdata, got.rdata);
            if (got.video !== want.video) flag_mismatch("video_access", want.video, got.video);
            if (got.bad !== want.bad) flag_mismatch("bad_address", want.bad, got.bad);
            if (got.irq !== want.irq) flag_mismatch("timer_irq_pending", want.irq, got.irq);
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_command;
    logic [7:0] i_reg_address;
    logic [7:0] i_write_value;
    logic [7:0] i_tick_cycles;
    logic [7:0] i_button_state;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_read_value;
    logic       o_video_access;
    logic       o_bad_address;
    logic       o_timer_irq_pending;

    io_page_board board = new();
    bit           pace_on = 1'b0;
    int           quiet_cycles = 0;

    timer_joypad_io_registers dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_command          (i_command),
        .i_reg_address      (i_reg_address),
        .i_write_value      (i_write_value),
        .i_tick_cycles      (i_tick_cycles),
        .i_button_state     (i_button_state),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_read_value       (o_read_value),
        .o_video_access     (o_video_access),
        .o_bad_address      (o_bad_address),
        .o_timer_irq_pending(o_timer_irq_pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic bus_item_t make_item(logic [1:0] cmd, logic [7:0] addr, logic [7:0] data,
                                            logic [7:0] cycles, logic [7:0] buttons);
        bus_item_t it;
        it = {cmd, addr, data, cycles, buttons};
        return it;
    endfunction

    // Any address with a defined meaning, plus gaps inside the ranges, a hole and random bytes
    function automatic logic [7:0] known_addr();
        case ($urandom_range(0, 13))
            0:       return ADDR_JOYP;
            1:       return ADDR_SB;
            2:       return ADDR_SC;
            3:       return ADDR_DIV;
            4:       return ADDR_TIMA;
            5:       return ADDR_TMA;
            6:       return ADDR_TAC;
            7:       return ADDR_KEY1;
            8:       return ADDR_SPARE;
            9:       return 8'($urandom_range(VIDEO_A_LO, VIDEO_B_HI));
            10:      return 8'($urandom_range(AUDIO_A_LO, AUDIO_D_HI));
            11:      return ADDR_HOLE;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic bus_item_t random_item();
        bus_item_t it;
        int        pick;
        int        row;
        it   = {2'($urandom), $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            it.command = CMD_TICK;
            if ($urandom_range(0, 7) == 0) it.cycles = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end else if (pick < 62) begin
            it.command = CMD_READ;
            it.address = known_addr();
        end else if (pick < 88) begin
            it.command = CMD_WRITE;
            row = $urandom_range(0, 99);
            if (row < 30) it.address = ADDR_JOYP;
            else if (row < 50) it.address = ADDR_TAC;
            else if (row < 65) it.address = ADDR_TMA;
            else if (row < 72) it.address = ADDR_TIMA;
            else if (row < 80) it.address = ADDR_DIV;
            else it.address = known_addr();
            if (it.address == ADDR_TAC && $urandom_range(0, 3) != 0)
                it.wdata[TAC_ENABLE_BIT] = 1'b1;
        end else if (pick < 95) begin
            it.command = 2'($urandom);
        end else begin
            it.command = CMD_NONE;
        end
        return it;
    endfunction

    // Present one item and hold it until taken; then maybe leave a gap
    task automatic send_item(bus_item_t it);
        i_valid        <= 1'b1;
        i_command      <= it.command;
        i_reg_address  <= it.address;
        i_write_value  <= it.wdata;
        i_tick_cycles  <= it.cycles;
        i_button_state <= it.buttons;
        do @(posedge i_clk); while (o_stall);
        board.apply_item(it);
        if (pace_on && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // Receiver stalls in bursts while pacing is on
    initial begin : reply_pacing
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pace_on && $urandom_range(0, 9) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Compare every reply taken by the receiver
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_reply({o_read_value, o_video_access, o_bad_address, o_timer_irq_pending});
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timer_joypad_io_registers_test: errors");
            $finish;
        end
    end

    initial begin : stimulus
        bus_item_t  it;
        logic [7:0] tac;
        int         sent;
        int         len;
        int         pick;

        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_command      <= CMD_TICK;
        i_reg_address  <= '0;
        i_write_value  <= '0;
        i_tick_cycles  <= '0;
        i_button_state <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset values, read map corners, joypad rows, timer basics
        send_item(make_item(CMD_READ, ADDR_JOYP, 8'h00, 8'h00, 8'h00));
        send_item(make_item(CMD_READ, ADDR_SB, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_item(CMD_READ, ADDR_DIV, 8'h00, 8'h00, 8'h00));
        send_item(make_item(CMD_READ, ADDR_TIMA, 8'h00, 8'h00, 8'h00));
        send_item(make_item(CMD_READ, ADDR_KEY1, 8'h00, 8'h00, 8'h00));
        send_item(make_item(CMD_READ, ADDR_SPARE, 8'h00, 8'h00, 8'h00));
        send_item(make_item(CMD_READ, VIDEO_A_LO, 8'h00, 8'h00, 8'h00));
        send_item(make_item(CMD_READ, VIDEO_GAP, 8'h00, 8'h00, 8'h00));
        send_item(make_item(CMD_READ, AUDIO_GAP, 8'h00, 8'h00, 8'h00));
        send_item(make_item(CMD_READ, AUDIO_D_HI, 8'h00, 8'h00, 8'h00));
        send_item(make_item(CMD_READ, ADDR_TOP, 8'h00, 8'h00, 8'h00));
        send_item(make_item(CMD_WRITE, ADDR_JOYP, 8'h10, 8'h00, 8'hA5));
        send_item(make_item(CMD_WRITE, ADDR_JOYP, 8'h20, 8'h00, 8'h5A));
        send_item(make_item(CMD_READ, ADDR_JOYP, 8'h00, 8'h00, 8'h00));
        send_item(make_item(CMD_WRITE, ADDR_JOYP, 8'hFF, 8'h00, 8'h00));
        send_item(make_item(CMD_WRITE, ADDR_KEY1, 8'hFF, 8'h00, 8'h00));
        send_item(make_item(CMD_WRITE, ADDR_SPARE, 8'hFF, 8'h00, 8'h00));
        send_item(make_item(CMD_WRITE, VIDEO_B_HI, 8'hFF, 8'h00, 8'h00));
        send_item(make_item(CMD_WRITE, ADDR_TMA, 8'hFF, 8'h00, 8'h00));
        send_item(make_item(CMD_WRITE, ADDR_TAC, 8'h05, 8'h00, 8'h00));
        send_item(make_item(CMD_WRITE, ADDR_TIMA, 8'hFF, 8'h00, 8'h00));
        send_item(make_item(CMD_TICK, 8'h00, 8'h00, 8'hFF, 8'h00));
        send_item(make_item(CMD_TICK, 8'h00, 8'h00, 8'h00, 8'h00));
        send_item(make_item(CMD_NONE, ADDR_TIMA, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_item(CMD_WRITE, ADDR_DIV, 8'h00, 8'h00, 8'h00));

        // Random: timer runs that reach counter wrap, mixed with register traffic
        sent = 0;
        while (sent < ITEM_TOTAL) begin
            pace_on = (sent < ITEM_TOTAL - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) != 0) begin
                tac = 8'($urandom);
                tac[TAC_ENABLE_BIT] = ($urandom_range(0, 5) != 0);
                if ($urandom_range(0, 1) == 1) tac[1:0] = TAC_MODE_MUL16;
                send_item(make_item(CMD_WRITE, ADDR_TMA, 8'($urandom), 8'($urandom), 8'($urandom)));
                send_item(make_item(CMD_WRITE, ADDR_TAC, tac, 8'($urandom), 8'($urandom)));
                if ($urandom_range(0, 3) == 0)
                    send_item(make_item(CMD_WRITE, ADDR_TIMA, 8'($urandom), 8'($urandom),
                                        8'($urandom)));
                len = $urandom_range(10, 60);
                repeat (len) begin
                    pick = $urandom_range(0, 9);
                    it   = random_item();
                    if (pick < 7) begin
                        it.command = CMD_TICK;
                        if ($urandom_range(0, 3) != 0) it.cycles = 8'($urandom_range(128, 255));
                    end else if (pick < 9) begin
                        it.command = CMD_READ;
                        case ($urandom_range(0, 3))
                            0:       it.address = ADDR_TIMA;
                            1:       it.address = ADDR_DIV;
                            2:       it.address = ADDR_TMA;
                            default: it.address = ADDR_TAC;
                        endcase
                    end
                    send_item(it);
                end
                sent += len + 3;
            end else begin
                repeat (20) send_item(random_item());
                sent += 20;
            end
        end
        i_valid <= 1'b0;
        pace_on = 1'b0;

        while (board.pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending_replies.size() == 0)
            $display("timer_joypad_io_registers_test: clean");
        else
            $display("timer_joypad_io_registers_test: errors");
        $finish;
    end

endmodule

/* timer_joypad_io_registers.f */
rtl/core/tjr_pkg.sv
rtl/core/tjr_addr_dec.sv
rtl/core/tjr_state.sv
rtl/core/timer_joypad_io_registers.sv
tb/timer_joypad_io_registers_test.sv
